@@ rtl/core/bmrsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmrsc_pkg
// Shared widths and the command and status types that join the controller
// and the datapath of the bitmap run set/clear block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrsc_pkg;

  localparam int START_W     = 12;
  localparam int COUNT_W     = 13;
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 64;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam int DEF_MAP_WORDS = 64;
  localparam int DEF_WORD_BITS = 64;

  // operation carried in the input tuser bit
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic clr;   // write zero to the next word of the clearing pass
    logic load;  // take a new item
    logic step;  // split the start bit into word and offset
    logic rd;    // read the current word
    logic wr;    // modify, write back and present the current word
  } bmrsc_cmd_t;

  typedef struct packed {
    logic clr_done;   // clearing pass writes its final word this cycle
    logic none;       // the item touches no word
    logic word_last;  // current word is the last of the run
    logic out_free;   // output register can take a word
  } bmrsc_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_range_set_clear.sv @@
// ----------------------------------------------------------------------------
// bitmap_range_set_clear
// Bitmap of MAP_WORDS words of WORD_BITS bits; each item sets or clears a run
// of bits and the block streams out every word the run touched.
//
// Input channel in_*: one item per request, mode in in_tuser, start bit and
// bit count in in_tdata. Output channel out_*: one item per word touched, in
// ascending word order, out_tlast on the final word. A zero count, or a start
// past the map, gives no output item; a run past the map end is clipped.
// Sequence: an item is accepted, the start bit is split into word and offset,
// then each word touched gets a memory read, then a modify and write back
// through the single memory port. The first word is valid in the output
// register after the first write-back; a rejected item goes back to idle
// from the split state, with no read or write.
// After reset a clearing pass writes zero to every memory word,
// with in_tready low. The output register holds a word until it is taken;
// while the receiver stalls the run pauses at its next write-back, and a new
// item is accepted while the final word still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_range_set_clear
  import bmrsc_pkg::*;
#(
  parameter int MAP_WORDS = DEF_MAP_WORDS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // start_bit[11:0], bit_count[24:12]
  input  wire logic                   in_tuser,   // mode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // word_index[5:0], word_value[69:6]
  output logic                        out_tlast
);

  bmrsc_cmd_t        cmd;
  bmrsc_sts_t        sts;
  logic [IDX_W-1:0]  out_index;
  logic [VAL_W-1:0]  out_value;

  bmrsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmrsc_dp #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser),
    .in_start   (in_tdata[START_W-1:0]),
    .in_count   (in_tdata[START_W+COUNT_W-1:START_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_index  (out_index),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'({out_value, out_index});

endmodule

`default_nettype wire

@@ rtl/core/bmrsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmrsc_ctrl
// Sequencer: clearing pass after reset, division of the start bit into word
// and offset, then one read and one write-back per word of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrsc_ctrl
  import bmrsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire bmrsc_sts_t sts,
  output bmrsc_cmd_t      cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.none) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.wr    = 1'b1;
          state_nxt = sts.word_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_wr_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> sts.out_free)
    else $error("word written while output register is full");

  a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr && sts.word_last |=> in_tready)
    else $error("not ready for a new item after the last word");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr && sts.clr_done |=> in_tready && !cmd.clr)
    else $error("clearing pass did not end");

  a_no_ready_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !in_tready)
    else $error("ready while a word is being modified");

endmodule

`default_nettype wire

@@ rtl/core/bmrsc_dp.sv @@
// ----------------------------------------------------------------------------
// bmrsc_dp
// Datapath: bitmap memory, clear counter, reciprocal split of the start bit
// into word and offset, run mask generation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrsc_dp
  import bmrsc_pkg::*;
#(
  parameter int MAP_WORDS = DEF_MAP_WORDS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bmrsc_cmd_t         cmd,
  output bmrsc_sts_t              sts,
  input  wire logic               in_mode,
  input  wire logic [START_W-1:0] in_start,
  input  wire logic [COUNT_W-1:0] in_count,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [IDX_W-1:0]        out_index,
  output logic [VAL_W-1:0]        out_value,
  output logic                    out_last
);

  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW         = $clog2(MAP_WORDS + 1);
  localparam int LW         = $clog2(WORD_BITS);
  localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;
  localparam int TW_RAW     = $clog2(TOTAL_BITS + 1);
  localparam int TW         = (TW_RAW > COUNT_W) ? TW_RAW : COUNT_W;

  // reciprocal of the word width, exact for every start bit
  localparam int RK = START_W + LW;
  localparam int RM = (2 ** RK + WORD_BITS - 1) / WORD_BITS;
  localparam int MW = START_W + 2;
  localparam int PW = START_W + MW;

  localparam logic [TW-1:0] TOTAL_T   = TW'(TOTAL_BITS);
  localparam logic [LW:0]   WB_L      = (LW + 1)'(WORD_BITS);
  localparam logic [CW-1:0] CLR_LAST  = CW'(MAP_WORDS - 1);
  localparam logic [MW-1:0] RECIP     = MW'(RM);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic [CW-1:0]        clr_addr_r;
  logic                 out_valid_r;
  logic                 mode_r;
  logic                 none_r;
  logic [START_W-1:0]   word_r;      // start bit, then word counter
  logic [LW-1:0]        rem_r;       // offset of the run in the current word
  logic [COUNT_W-1:0]   cnt_r;       // bits of the run still to do
  logic [WORD_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     out_index_r;
  logic [WORD_BITS-1:0] out_value_r;
  logic                 out_last_r;

  // load-time clip against the map end
  logic [TW-1:0]      start_ext;
  logic [TW-1:0]      avail;
  logic [COUNT_W-1:0] clip_count;
  logic               load_none;

  assign start_ext  = TW'(in_start);
  assign avail      = TOTAL_T - start_ext;
  assign load_none  = (in_count == '0) || (start_ext >= TOTAL_T);
  assign clip_count = (TW'(in_count) < avail) ? in_count : avail[COUNT_W-1:0];

  // word and offset of the start bit
  logic [PW-1:0]      prod;
  logic [START_W-1:0] quo;
  logic [START_W-1:0] quo_wb;
  logic [START_W-1:0] rem_full;

  assign prod     = PW'(word_r) * PW'(RECIP);
  assign quo      = START_W'(prod >> RK);
  assign quo_wb   = quo * START_W'(WORD_BITS);
  assign rem_full = word_r - quo_wb;

  // word modify
  logic [LW:0]          room;
  logic                 is_last;
  logic [LW:0]          take;
  logic [LW:0]          shr;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] new_value;

  assign room      = WB_L - (LW + 1)'(rem_r);
  assign is_last   = (cnt_r <= COUNT_W'(room));
  assign take      = is_last ? cnt_r[LW:0] : room;
  assign shr       = WB_L - take;
  assign mask      = ({WORD_BITS{1'b1}} >> shr) << rem_r;
  assign new_value = (mode_r == MODE_CLEAR) ? (rd_data_r & ~mask) : (rd_data_r | mask);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r[AW-1:0]] <= '0;
    end else if (cmd.wr) begin
      mem[word_r[AW-1:0]] <= new_value;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[word_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + CW'(1);
      if (cmd.wr) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      none_r    <= load_none;
      word_r    <= in_start;
      rem_r     <= '0;
      cnt_r     <= clip_count;
    end else if (cmd.step) begin
      word_r    <= quo;
      rem_r     <= rem_full[LW-1:0];
    end else if (cmd.wr) begin
      word_r    <= word_r + START_W'(1);
      rem_r     <= '0;
      cnt_r     <= cnt_r - COUNT_W'(take);
    end
    if (cmd.wr) begin
      out_index_r <= word_r[IDX_W-1:0];
      out_value_r <= new_value;
      out_last_r  <= is_last;
    end
  end

  assign sts.clr_done  = (clr_addr_r == CLR_LAST);
  assign sts.none      = none_r;
  assign sts.word_last = is_last;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_index  = out_index_r;
  assign out_value  = VAL_W'(out_value_r);
  assign out_last   = out_last_r;

endmodule

`default_nettype wire
